// ===== rtl/psat_pkg.sv =====
// Shared types and codes for the peer slot assignment table.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package psat_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int KEY_W = 50;

	localparam logic [2:0] FN_BEGIN = 3'd0;
	localparam logic [2:0] FN_WRITE_OK = 3'd1;
	localparam logic [2:0] FN_ABORT = 3'd2;
	localparam logic [2:0] FN_DISCONNECT = 3'd3;
	localparam logic [2:0] FN_SLOT_IDLE = 3'd4;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NO_SLOT = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_MARK = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	typedef struct packed {
		logic [2:0] func;
		logic [1:0] peer_type;
		logic [47:0] peer_address;
		logic [7:0] slot_index;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] slot_out;
		logic [1:0] expected_action;
		logic request_disconnect;
	} result_item_t;

	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctrl_t;

	typedef struct packed {
		logic hit;
		logic inv;
		logic free;
	} scan_flags_t;

endpackage
`default_nettype wire

// ===== rtl/psat_key_mem.sv =====
// Key store of the slot table: one write port, one registered read port.
// Depends on psat_pkg for the key width.
`default_nettype none
module psat_key_mem #(
	parameter int DEPTH = psat_pkg::SLOT_COUNT_DEF,
	parameter int IW = 4
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [IW-1:0] waddr,
	input wire logic [psat_pkg::KEY_W-1:0] wdata,
	input wire logic [IW-1:0] raddr,
	output logic [psat_pkg::KEY_W-1:0] rdata
);

	logic [psat_pkg::KEY_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/psat_scan_unit.sv =====
// Shared compare unit: checks one table entry per step and keeps the first
// key match, first invalid entry and first free entry. Depends on psat_pkg.
`default_nettype none
module psat_scan_unit #(
	parameter int IW = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire psat_pkg::scan_ctrl_t ctrl,
	input wire logic [IW-1:0] idx,
	input wire logic [psat_pkg::KEY_W-1:0] key,
	input wire logic [psat_pkg::KEY_W-1:0] entry_key,
	input wire logic entry_valid,
	input wire logic entry_in_use,
	output psat_pkg::scan_flags_t flags,
	output logic [IW-1:0] hit_idx,
	output logic [IW-1:0] inv_idx,
	output logic [IW-1:0] free_idx
);

	psat_pkg::scan_flags_t flags_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] inv_idx_q;
	logic [IW-1:0] free_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (ctrl.clear) begin
			flags_q <= '0;
		end else if (ctrl.step) begin
			if (!flags_q.hit && entry_valid && (entry_key == key)) begin
				flags_q.hit <= 1'b1;
			end
			if (!flags_q.inv && !entry_valid) begin
				flags_q.inv <= 1'b1;
			end
			if (!flags_q.free && !entry_in_use) begin
				flags_q.free <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			if (!flags_q.hit) begin
				hit_idx_q <= idx;
			end
			if (!flags_q.inv) begin
				inv_idx_q <= idx;
			end
			if (!flags_q.free) begin
				free_idx_q <= idx;
			end
		end
	end

	assign flags = flags_q;
	assign hit_idx = hit_idx_q;
	assign inv_idx = inv_idx_q;
	assign free_idx = free_idx_q;

endmodule
`default_nettype wire

// ===== rtl/peer_slot_assignment_table_unit.sv =====
// Top level of the peer slot assignment table: sequencer, slot flags and
// pending record. Depends on psat_pkg, psat_key_mem and psat_scan_unit.
//
// A command item is taken at a rising edge where start is high and busy is
// low. Exactly one result item follows: it is shown on result for a single
// cycle, marked by done, and the receiver cannot hold it off.
// A begin command walks the key store one entry per cycle through the
// shared compare unit, over the key memory's single read port, and then
// passes S_LAST and S_EXEC; every other command goes from S_IDLE straight
// to S_EXEC, and done is registered from S_EXEC.
// busy stays high from acceptance until the cycle in which done is shown;
// a new command may be accepted in the same cycle as done.
// Reset clears all valid and in-use marks and drops any pending assignment;
// the key memory needs no clearing since a key is only compared while its
// entry is valid.
`default_nettype none
module peer_slot_assignment_table_unit #(
	parameter int SLOT_COUNT = psat_pkg::SLOT_COUNT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire psat_pkg::cmd_item_t cmd,
	output logic done,
	output psat_pkg::result_item_t result
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PW = $clog2(SLOT_COUNT + 1);
	localparam logic [PW-1:0] NONE_IDX = PW'(SLOT_COUNT);
	localparam logic [PW-1:0] LAST_IDX = PW'(SLOT_COUNT - 1);
	localparam logic [4:0] NONE_OUT = 5'(SLOT_COUNT);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_LAST = 4'b0100,
		S_EXEC = 4'b1000
	} state_t;

	state_t state_q;
	logic [PW-1:0] cnt_q;
	logic rd_vld_s1;
	logic [IW-1:0] idx_s1;

	logic [2:0] func_q;
	logic [psat_pkg::KEY_W-1:0] key_q;
	logic [7:0] idle_q;

	logic [SLOT_COUNT-1:0] valid_q;
	logic [SLOT_COUNT-1:0] in_use_q;
	logic [PW-1:0] pend_q;
	logic pend_was_valid_q;
	logic pend_comm_q;

	logic done_q;
	psat_pkg::result_item_t result_q;

	logic accept;
	psat_pkg::scan_ctrl_t scan_ctrl;
	psat_pkg::scan_flags_t scan_flags;
	logic [IW-1:0] hit_idx;
	logic [IW-1:0] inv_idx;
	logic [IW-1:0] free_idx;
	logic [psat_pkg::KEY_W-1:0] mem_rdata;

	logic [SLOT_COUNT-1:0] valid_d;
	logic [SLOT_COUNT-1:0] in_use_d;
	logic [PW-1:0] pend_d;
	logic pend_was_valid_d;
	logic pend_comm_d;
	psat_pkg::result_item_t res_d;
	logic mem_we;
	logic [IW-1:0] mem_waddr;
	logic have;
	logic [IW-1:0] pend_idx;
	logic [IW-1:0] idle_idx;
	logic [IW-1:0] f_idx;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign scan_ctrl.clear = accept;
	assign scan_ctrl.step = rd_vld_s1;

	psat_key_mem #(
		.DEPTH(SLOT_COUNT),
		.IW(IW)
	) u_key_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(key_q),
		.raddr(cnt_q[IW-1:0]),
		.rdata(mem_rdata)
	);

	psat_scan_unit #(
		.IW(IW)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(scan_ctrl),
		.idx(idx_s1),
		.key(key_q),
		.entry_key(mem_rdata),
		.entry_valid(valid_q[idx_s1]),
		.entry_in_use(in_use_q[idx_s1]),
		.flags(scan_flags),
		.hit_idx(hit_idx),
		.inv_idx(inv_idx),
		.free_idx(free_idx)
	);

	assign have = (pend_q < NONE_IDX);
	assign pend_idx = pend_q[IW-1:0];
	assign idle_idx = idle_q[IW-1:0];

	always_comb begin
		valid_d = valid_q;
		in_use_d = in_use_q;
		pend_d = pend_q;
		pend_was_valid_d = pend_was_valid_q;
		pend_comm_d = pend_comm_q;
		mem_we = 1'b0;
		f_idx = hit_idx;
		mem_waddr = hit_idx;
		res_d.status = psat_pkg::ST_IGNORED;
		res_d.slot_out = NONE_OUT;
		res_d.expected_action = psat_pkg::ACT_NONE;
		res_d.request_disconnect = 1'b0;
		if (state_q == S_EXEC) begin
			case (func_q)
				psat_pkg::FN_BEGIN: begin
					if (scan_flags.hit || scan_flags.inv || scan_flags.free) begin
						if (scan_flags.hit) begin
							f_idx = hit_idx;
							pend_was_valid_d = 1'b1;
						end else if (scan_flags.inv) begin
							f_idx = inv_idx;
							pend_was_valid_d = 1'b0;
							mem_we = 1'b1;
						end else begin
							f_idx = free_idx;
							pend_was_valid_d = 1'b1;
							mem_we = 1'b1;
						end
						mem_waddr = f_idx;
						valid_d[f_idx] = 1'b1;
						in_use_d[f_idx] = 1'b0;
						pend_d = PW'(f_idx);
						pend_comm_d = 1'b0;
						res_d.status = psat_pkg::ST_DONE;
						res_d.slot_out = 5'(f_idx);
					end else begin
						res_d.status = psat_pkg::ST_NO_SLOT;
						res_d.request_disconnect = 1'b1;
					end
				end
				psat_pkg::FN_WRITE_OK: begin
					res_d.request_disconnect = 1'b1;
					if (have) begin
						in_use_d[pend_idx] = 1'b1;
						pend_comm_d = 1'b1;
						res_d.status = psat_pkg::ST_DONE;
						res_d.slot_out = 5'(pend_idx);
						res_d.expected_action = psat_pkg::ACT_MARK;
					end
				end
				psat_pkg::FN_ABORT, psat_pkg::FN_DISCONNECT: begin
					res_d.request_disconnect = (func_q == psat_pkg::FN_ABORT);
					if (have) begin
						res_d.status = psat_pkg::ST_DONE;
						res_d.slot_out = 5'(pend_idx);
						if (func_q == psat_pkg::FN_ABORT || !pend_comm_q) begin
							in_use_d[pend_idx] = 1'b0;
							if (!pend_was_valid_q) begin
								valid_d[pend_idx] = 1'b0;
							end
							res_d.expected_action = psat_pkg::ACT_CLEAR;
						end
						pend_d = NONE_IDX;
						pend_was_valid_d = 1'b0;
						pend_comm_d = 1'b0;
					end
				end
				psat_pkg::FN_SLOT_IDLE: begin
					if ((idle_q < 8'(SLOT_COUNT)) && valid_q[idle_idx]) begin
						valid_d[idle_idx] = 1'b0;
						in_use_d[idle_idx] = 1'b0;
						res_d.status = psat_pkg::ST_DONE;
						res_d.slot_out = 5'(idle_idx);
						res_d.expected_action = psat_pkg::ACT_CLEAR;
					end
				end
				default: begin
					res_d.status = psat_pkg::ST_IGNORED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			valid_q <= '0;
			in_use_q <= '0;
			pend_q <= NONE_IDX;
			pend_was_valid_q <= 1'b0;
			pend_comm_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			done_q <= (state_q == S_EXEC);
			valid_q <= valid_d;
			in_use_q <= in_use_d;
			pend_q <= pend_d;
			pend_was_valid_q <= pend_was_valid_d;
			pend_comm_q <= pend_comm_d;
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= (cmd.func == psat_pkg::FN_BEGIN) ? S_SCAN : S_EXEC;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + PW'(1);
					if (cnt_q == LAST_IDX) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IW-1:0];
		if (accept) begin
			func_q <= cmd.func;
			key_q <= {cmd.peer_type, cmd.peer_address};
			idle_q <= cmd.slot_index;
		end
		if (state_q == S_EXEC) begin
			result_q <= res_d;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ===== tb/peer_slot_assignment_table_unit_tb.sv =====
// Self-checking testbench for peer_slot_assignment_table_unit: directed and random
// onboarding commands are driven, and every result item is checked against a
// predictor of the slot table. Depends on psat_pkg and the block's RTL only.
`timescale 1ns / 1ps
module peer_slot_assignment_table_unit_tb;
	import psat_pkg::*;

	localparam int SLOTS = SLOT_COUNT_DEF;
	localparam logic [4:0] NO_SLOT = 5'(SLOTS);
	localparam int POOL_SIZE = 24;
	localparam int ITEM_TARGET = 1900;

	class slot_table_tracker;
		bit valid[SLOTS];
		bit in_use[SLOTS];
		logic [49:0] key_of[SLOTS];
		int pend_slot;
		bit pend_was_valid;
		bit pend_committed;
		result_item_t awaited[$];
		int failures;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				valid[i] = 1'b0;
				in_use[i] = 1'b0;
				key_of[i] = '0;
			end
			drop_pending();
			failures = 0;
		endfunction

		function void drop_pending();
			pend_slot = SLOTS;
			pend_was_valid = 1'b0;
			pend_committed = 1'b0;
		endfunction

		function void roll_back(int s);
			in_use[s] = 1'b0;
			if (!pend_was_valid) begin
				valid[s] = 1'b0;
				key_of[s] = '0;
			end
		endfunction

		function void take_command(cmd_item_t c);
			result_item_t r;
			logic [49:0] key;
			int f;
			int s;
			bit have;
			r.status = ST_IGNORED;
			r.slot_out = NO_SLOT;
			r.expected_action = ACT_NONE;
			r.request_disconnect = 1'b0;
			key = {c.peer_type, c.peer_address};
			s = pend_slot;
			have = s < SLOTS;
			case (c.func)
				FN_BEGIN: begin
					f = -1;
					for (int i = 0; i < SLOTS && f < 0; i++)
						if (valid[i] && key_of[i] == key)
							f = i;
					for (int i = 0; i < SLOTS && f < 0; i++)
						if (!valid[i])
							f = i;
					for (int i = 0; i < SLOTS && f < 0; i++)
						if (!in_use[i])
							f = i;
					if (f < 0) begin
						r.status = ST_NO_SLOT;
						r.request_disconnect = 1'b1;
					end else begin
						pend_slot = f;
						pend_was_valid = valid[f];
						pend_committed = 1'b0;
						key_of[f] = key;
						valid[f] = 1'b1;
						in_use[f] = 1'b0;
						r.status = ST_DONE;
						r.slot_out = 5'(f);
					end
				end
				FN_WRITE_OK: begin
					r.request_disconnect = 1'b1;
					if (have) begin
						in_use[s] = 1'b1;
						pend_committed = 1'b1;
						r.status = ST_DONE;
						r.slot_out = 5'(s);
						r.expected_action = ACT_MARK;
					end
				end
				FN_ABORT: begin
					r.request_disconnect = 1'b1;
					if (have) begin
						roll_back(s);
						drop_pending();
						r.status = ST_DONE;
						r.slot_out = 5'(s);
						r.expected_action = ACT_CLEAR;
					end
				end
				FN_DISCONNECT: begin
					if (have) begin
						if (!pend_committed) begin
							roll_back(s);
							r.expected_action = ACT_CLEAR;
						end
						drop_pending();
						r.status = ST_DONE;
						r.slot_out = 5'(s);
					end
				end
				FN_SLOT_IDLE: begin
					if (c.slot_index < SLOTS && valid[c.slot_index]) begin
						in_use[c.slot_index] = 1'b0;
						valid[c.slot_index] = 1'b0;
						key_of[c.slot_index] = '0;
						r.status = ST_DONE;
						r.slot_out = 5'(c.slot_index);
						r.expected_action = ACT_CLEAR;
					end
				end
				default: ;
			endcase
			awaited.push_back(r);
		endfunction

		function void check_result(result_item_t got);
			result_item_t exp;
			if (awaited.size() == 0) begin
				$error("result item with no command outstanding: %p", got);
				failures++;
				return;
			end
			exp = awaited.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				failures++;
			end
			if (got.slot_out !== exp.slot_out) begin
				$error("slot_out: expected %0d, got %0d", exp.slot_out, got.slot_out);
				failures++;
			end
			if (got.expected_action !== exp.expected_action) begin
				$error("expected_action: expected %0d, got %0d",
					exp.expected_action, got.expected_action);
				failures++;
			end
			if (got.request_disconnect !== exp.request_disconnect) begin
				$error("request_disconnect: expected %0d, got %0d",
					exp.request_disconnect, got.request_disconnect);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_item_t cmd;
	logic done;
	result_item_t result;

	slot_table_tracker tracker;
	int items_sent;
	bit quiet_stretch;
	logic [49:0] key_pool[POOL_SIZE];

	peer_slot_assignment_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			tracker.check_result(result);
	end

	function automatic int pick_gap();
		int r;
		if ($urandom_range(0, 149) == 0)
			quiet_stretch = !quiet_stretch;
		if (quiet_stretch)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [49:0] random_key();
		return {2'($urandom), 16'($urandom), 32'($urandom)};
	endfunction

	function automatic cmd_item_t make_cmd(logic [2:0] func, logic [49:0] key, logic [7:0] idx);
		cmd_item_t c;
		c.func = func;
		c.peer_type = key[49:48];
		c.peer_address = key[47:0];
		c.slot_index = idx;
		return c;
	endfunction

	task automatic send_command(cmd_item_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = c;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.take_command(c);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_simple(logic [2:0] func);
		send_command(make_cmd(func, random_key(), 8'($urandom)));
	endtask

	task automatic send_begin(logic [49:0] key);
		send_command(make_cmd(FN_BEGIN, key, 8'($urandom)));
	endtask

	task automatic send_idle(logic [7:0] idx);
		send_command(make_cmd(FN_SLOT_IDLE, random_key(), idx));
	endtask

	task automatic onboard_and_close(logic [49:0] key);
		int r;
		send_begin(key);
		r = $urandom_range(0, 9);
		if (r < 5) begin
			send_simple(FN_WRITE_OK);
			send_simple(FN_DISCONNECT);
		end else if (r < 7) begin
			send_simple(FN_ABORT);
		end else if (r < 9) begin
			send_simple(FN_DISCONNECT);
		end
	endtask

	initial begin
		int kind;
		tracker = new();
		items_sent = 0;
		quiet_stretch = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Commands that find nothing to act on, then unknown function codes.
		send_simple(FN_WRITE_OK);
		send_simple(FN_ABORT);
		send_simple(FN_DISCONNECT);
		send_idle(8'd0);
		send_idle(8'd255);
		send_idle(8'(SLOTS));
		send_command(make_cmd(3'd5, {2'b11, 48'hFFFF_FFFF_FFFF}, 8'hFF));
		send_command(make_cmd(3'd6, '0, 8'h00));
		send_command(make_cmd(3'd7, random_key(), 8'($urandom)));

		// Onboarding at the key extremes, replacing a pending slot without rollback,
		// known keys, commit, rollback and freeing a slot that is still pending.
		send_begin({2'b11, 48'hFFFF_FFFF_FFFF});
		send_begin(50'd0);
		send_simple(FN_WRITE_OK);
		send_simple(FN_DISCONNECT);
		send_begin({2'b11, 48'hFFFF_FFFF_FFFF});
		send_simple(FN_ABORT);
		send_begin({2'b10, 48'h5555_5555_5555});
		send_simple(FN_DISCONNECT);
		send_begin({2'b01, 48'hAAAA_AAAA_AAAA});
		send_idle(8'd2);
		send_simple(FN_WRITE_OK);
		send_simple(FN_DISCONNECT);
		send_idle(8'(SLOTS - 1));
		send_idle(8'd1);

		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = random_key();

		while (items_sent < ITEM_TARGET) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				onboard_and_close(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
			end else if (kind < 63) begin
				// Commit more peers than there are slots, so that the table runs full.
				for (int i = 0; i <= SLOTS; i++) begin
					send_begin(key_pool[i]);
					send_simple(FN_WRITE_OK);
					send_simple(FN_DISCONNECT);
				end
				send_begin(random_key());
				send_simple(FN_WRITE_OK);
			end else if (kind < 75) begin
				if ($urandom_range(0, 4) == 0)
					send_idle(8'($urandom));
				else
					send_idle(8'($urandom_range(0, SLOTS - 1)));
			end else if (kind < 78) begin
				key_pool[$urandom_range(0, POOL_SIZE - 1)] = random_key();
			end else begin
				send_command(make_cmd(3'($urandom), random_key(), 8'($urandom)));
			end
		end
		start = 1'b0;

		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 10) @(posedge clk);
		if (tracker.failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/psat_pkg.sv
rtl/psat_key_mem.sv
rtl/psat_scan_unit.sv
rtl/peer_slot_assignment_table_unit.sv
tb/peer_slot_assignment_table_unit_tb.sv
